### hw/rtl/meter_frame_checker_assert.svh
// Assertion helpers for the checker's top-level RTL; clock and reset come from the using scope.
`ifndef METER_FRAME_CHECKER_ASSERT_SVH
`define METER_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define MFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MFC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mfc_pkg.sv
package mfc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned POS_W = 15;

	localparam logic [POS_W-1:0] POS_LEN_FIRST  = 15'd1;
	localparam logic [POS_W-1:0] POS_LEN_SECOND = 15'd2;
	localparam logic [POS_W-1:0] POS_CTRL       = 15'd6;
	localparam logic [POS_W-1:0] POS_A1_FIRST   = 15'd7;
	localparam logic [POS_W-1:0] POS_A1_SECOND  = 15'd8;
	localparam logic [POS_W-1:0] POS_A2_FIRST   = 15'd9;
	localparam logic [POS_W-1:0] POS_A2_SECOND  = 15'd10;
	localparam logic [POS_W-1:0] POS_A3         = 15'd11;

	typedef enum logic [2:0] {
		FLD_NONE,
		FLD_LEN,
		FLD_CTRL,
		FLD_A1,
		FLD_A2,
		FLD_A3
	} fld_t;

	// One classified byte handed from front to back.
	typedef struct packed {
		logic       start;
		fld_t       fld;
		logic       high;
		logic       add;
		logic       last;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [15:0] place_byte(logic [15:0] w, logic [7:0] b, logic high);
		place_byte = high ? {b, w[7:0]} : {w[15:8], b};
	endfunction

endpackage

### hw/rtl/mfc_ifs.sv
interface mfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_begin;

	modport source (output valid, output frame_byte, output frame_begin, input ready);
	modport sink (input valid, input frame_byte, input frame_begin, output ready);
endinterface

interface mfc_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] user_length;
	logic [1:0]  protocol_flag;
	logic [7:0]  control_byte;
	logic [15:0] address_a1;
	logic [15:0] address_a2;
	logic [7:0]  address_a3;
	logic [7:0]  computed_sum;
	logic [7:0]  received_sum;
	logic        checksum_good;

	modport source (output valid, output user_length, output protocol_flag,
		output control_byte, output address_a1, output address_a2, output address_a3,
		output computed_sum, output received_sum, output checksum_good, input ready);
	modport sink (input valid, input user_length, input protocol_flag,
		input control_byte, input address_a1, input address_a2, input address_a3,
		input computed_sum, input received_sum, input checksum_good, output ready);
endinterface

interface mfc_cfg_if;
	logic valid;
	logic ready;
	logic big_endian_words;

	modport source (output valid, output big_endian_words, input ready);
	modport sink (input valid, input big_endian_words, output ready);
endinterface

### hw/rtl/meter_frame_checker.sv
// Throughput: one frame byte per cycle while the queue is not full; the per-byte counter step
// and the 8-bit checksum add keep pace, and the queue lets input and output stall independently.
// Path: a checksum byte enters the queue when it is accepted, and moves from the queue head
// into the output register once the output register is free to take it.
// Reset (arst_n low, asynchronous): frame state, queue and output valid clear; byte order
// resets to high byte first. No clearing pass; bytes are accepted as soon as reset is released.
module meter_frame_checker #(
	parameter int unsigned QUEUE_DEPTH = mfc_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	mfc_in_if.sink    frame_in,
	mfc_out_if.source result,
	mfc_cfg_if.sink   cfg
);

	`include "meter_frame_checker_assert.svh"

	logic             big_endian_q;
	logic             q_push;
	logic             q_pop;
	mfc_pkg::op_t     q_wdata;
	mfc_pkg::op_t     q_head;
	mfc_pkg::qstat_t  q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
		end else if (cfg.valid) begin
			big_endian_q <= cfg.big_endian_words;
		end
	end

	mfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.big_endian (big_endian_q),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	mfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	mfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.result (result)
	);

	`MFC_ASSERT_IMP(a_full_stalls_input, q_stat.full, !frame_in.ready, "input taken while queue full")
	`MFC_ASSERT_IMP(a_pop_needs_entry, q_pop, !q_stat.empty, "pop from empty queue")
	`MFC_ASSERT_IMP(a_last_waits_output, q_pop && q_head.last,
		!result.valid || result.ready, "checksum beat popped over a stalled result")
	`MFC_ASSERT_NXT(a_last_shows_result, q_pop && q_head.last && !q_head.start,
		result.valid, "checksum beat produced no result")

endmodule

### hw/rtl/mfc_front.sv
module mfc_front (
	input  logic                clk,
	input  logic                arst_n,
	mfc_in_if.sink              frame_in,
	input  logic                big_endian,
	input  mfc_pkg::qstat_t     q_stat,
	output logic                q_push,
	output mfc_pkg::op_t        q_wdata
);

	logic                       in_frame_q;
	logic [mfc_pkg::POS_W-1:0]  pos_q;
	logic [15:0]                len_q;

	logic                       accept;
	logic [mfc_pkg::POS_W-1:0]  end_pos;
	mfc_pkg::fld_t              fld;
	logic                       first;
	logic                       at_user;
	logic                       last;

	assign frame_in.ready = !q_stat.full;
	assign accept = frame_in.valid && frame_in.ready;
	assign end_pos = mfc_pkg::POS_CTRL + {1'b0, len_q[15:2]};
	assign at_user = (pos_q >= mfc_pkg::POS_CTRL);
	assign last = at_user && (pos_q == end_pos);

	always_comb begin
		fld = mfc_pkg::FLD_NONE;
		first = 1'b0;
		case (pos_q)
			mfc_pkg::POS_LEN_FIRST: begin
				fld = mfc_pkg::FLD_LEN;
				first = 1'b1;
			end
			mfc_pkg::POS_LEN_SECOND: fld = mfc_pkg::FLD_LEN;
			mfc_pkg::POS_CTRL: fld = mfc_pkg::FLD_CTRL;
			mfc_pkg::POS_A1_FIRST: begin
				fld = mfc_pkg::FLD_A1;
				first = 1'b1;
			end
			mfc_pkg::POS_A1_SECOND: fld = mfc_pkg::FLD_A1;
			mfc_pkg::POS_A2_FIRST: begin
				fld = mfc_pkg::FLD_A2;
				first = 1'b1;
			end
			mfc_pkg::POS_A2_SECOND: fld = mfc_pkg::FLD_A2;
			mfc_pkg::POS_A3: fld = mfc_pkg::FLD_A3;
			default: fld = mfc_pkg::FLD_NONE;
		endcase
	end

	always_comb begin
		q_wdata.start = frame_in.frame_begin;
		q_wdata.fld   = frame_in.frame_begin ? mfc_pkg::FLD_NONE : fld;
		q_wdata.high  = big_endian ? first : !first;
		q_wdata.add   = at_user && !last;
		q_wdata.last  = !frame_in.frame_begin && last;
		q_wdata.data  = frame_in.frame_byte;
		// drop idle bytes and the unchecked header bytes
		q_push = accept && (frame_in.frame_begin ||
			(in_frame_q && (fld != mfc_pkg::FLD_NONE || at_user)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			if (frame_in.frame_begin) begin
				in_frame_q <= 1'b1;
				pos_q <= mfc_pkg::POS_LEN_FIRST;
				len_q <= '0;
			end else if (in_frame_q) begin
				if (fld == mfc_pkg::FLD_LEN) begin
					len_q <= mfc_pkg::place_byte(len_q, frame_in.frame_byte,
						big_endian ? first : !first);
				end
				if (last) begin
					in_frame_q <= 1'b0;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/mfc_queue.sv
module mfc_queue #(
	parameter int unsigned DEPTH = mfc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfc_pkg::op_t     wdata,
	input  logic             pop,
	output mfc_pkg::op_t     head,
	output mfc_pkg::qstat_t  stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	mfc_pkg::op_t  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mfc_back.sv
module mfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mfc_pkg::op_t     head,
	input  mfc_pkg::qstat_t  q_stat,
	output logic             q_pop,
	mfc_out_if.source        result
);

	logic [15:0] len_q;
	logic [7:0]  sum_q;
	logic [7:0]  ctrl_q;
	logic [15:0] a1_q;
	logic [15:0] a2_q;
	logic [7:0]  a3_q;
	logic        out_valid_q;

	logic [15:0] len_n;
	logic [7:0]  ctrl_n;
	logic [15:0] a1_n;
	logic [15:0] a2_n;
	logic [7:0]  a3_n;
	logic        out_free;
	logic        load;

	assign out_free = !out_valid_q || result.ready;
	// hold a checksum beat until the output register can take it
	assign q_pop = !q_stat.empty && (!head.last || out_free);
	assign load = q_pop && !head.start && head.last;
	assign result.valid = out_valid_q;

	always_comb begin
		len_n = len_q;
		ctrl_n = ctrl_q;
		a1_n = a1_q;
		a2_n = a2_q;
		a3_n = a3_q;
		case (head.fld)
			mfc_pkg::FLD_LEN:  len_n = mfc_pkg::place_byte(len_q, head.data, head.high);
			mfc_pkg::FLD_CTRL: ctrl_n = head.data;
			mfc_pkg::FLD_A1:   a1_n = mfc_pkg::place_byte(a1_q, head.data, head.high);
			mfc_pkg::FLD_A2:   a2_n = mfc_pkg::place_byte(a2_q, head.data, head.high);
			mfc_pkg::FLD_A3:   a3_n = head.data;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			sum_q <= '0;
			ctrl_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			a3_q <= '0;
		end else if (q_pop) begin
			if (head.start) begin
				len_q <= '0;
				sum_q <= '0;
				ctrl_q <= '0;
				a1_q <= '0;
				a2_q <= '0;
				a3_q <= '0;
			end else begin
				len_q <= len_n;
				ctrl_q <= ctrl_n;
				a1_q <= a1_n;
				a2_q <= a2_n;
				a3_q <= a3_n;
				if (head.add) begin
					sum_q <= sum_q + head.data;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.user_length   <= len_n[15:2];
			result.protocol_flag <= len_n[1:0];
			result.control_byte  <= ctrl_n;
			result.address_a1    <= a1_n;
			result.address_a2    <= a2_n;
			result.address_a3    <= a3_n;
			result.computed_sum  <= sum_q;
			result.received_sum  <= head.data;
			result.checksum_good <= (sum_q == head.data);
		end
	end

endmodule
